@@ src/assert_macros.svh @@
// Assertion macros used by bounded_linked_list_engine_unit.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bll_pkg.sv @@
// Shared types and constants for the bounded linked list engine.
// No dependencies; imported by bounded_linked_list_engine_unit.
`default_nettype none

package bll_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int ACTION_WIDTH = 3;
  localparam int POS_WIDTH = 5;
  localparam int COUNT_BITS = 5;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_INSERT_FRONT = 3'd0,
    ACT_INSERT_BACK  = 3'd1,
    ACT_REMOVE_VALUE = 3'd2,
    ACT_REMOVE_POS   = 3'd3,
    ACT_CLEAR        = 3'd4,
    ACT_DUMP         = 3'd5
  } bll_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SEARCH,
    ST_DUMP,
    ST_RESP
  } bll_state_t;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0]       action;
    logic signed [VALUE_WIDTH-1:0] item_value;
    logic [POS_WIDTH-1:0]          position;
  } bll_req_t;

  typedef struct packed {
    logic                          ok;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic [COUNT_BITS-1:0]         count;
    logic                          last;
  } bll_resp_t;

endpackage

`default_nettype wire

@@ src/bounded_linked_list_engine_unit.sv @@
// Bounded singly linked list engine: value and link memories, free map, walk control.
// Depends on bll_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Ordered list of up to CAPACITY signed values, one request per transaction.
// An insert passes through accept, an update state and a response state.
// Clear and requests turned down at accept (full list on insert, empty list,
// position out of range, undefined action) pass through accept and a
// response state. Removal by value or position walks the list through a
// single-read-port link memory at one entry per cycle until the entry is
// reached (a value that is not found walks the whole list). Dump presents
// one result per cycle after a registered memory read, slower when the sink
// stalls.
// A new request is accepted only while the engine is idle, which includes the
// time a finished result waits in the output register. The link of the tail
// entry is never followed and is left unwritten on insert.
module bounded_linked_list_engine_unit
  import bll_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  bll_req_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output bll_resp_t out_data
);

  localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

  // Storage
  logic signed [VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [SW-1:0]                 link_mem  [CAPACITY];

  bll_state_t state, state_next;

  logic [CAPACITY-1:0] free_map;
  logic [SW-1:0]       head, tail;
  logic [CW-1:0]       entry_count;

  bll_action_t                   req_action;
  logic signed [VALUE_WIDTH-1:0] req_value;
  logic [CW-1:0]                 target;
  logic [SW-1:0]                 cur, prev;
  logic [CW-1:0]                 walk_idx;
  logic                          resp_ok;

  logic signed [VALUE_WIDTH-1:0] rd_value;
  logic [SW-1:0]                 rd_link;

  // Combinational control
  bll_action_t   act_in;
  logic          in_fire, out_free, out_load;
  logic [SW-1:0] alloc_slot;
  logic          at_end, is_match, pos_ok;
  logic [CMPW-1:0] pos_ext, count_ext;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          value_we, link_we;
  logic [SW-1:0] link_waddr, link_wdata;
  bll_resp_t     out_load_data;

  assign act_in    = bll_action_t'(in_data.action);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign pos_ext   = CMPW'(in_data.position);
  assign count_ext = CMPW'(entry_count);
  assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
  assign at_end    = (walk_idx + CW'(1)) == entry_count;
  assign is_match  = (req_action == ACT_REMOVE_VALUE) ? (rd_value == req_value)
                                                      : (walk_idx == target);

  // Lowest-numbered free slot
  always_comb begin
    alloc_slot = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (free_map[k]) alloc_slot = SW'(k);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (act_in)
            ACT_INSERT_FRONT,
            ACT_INSERT_BACK:  state_next = (free_map != '0) ? ST_INSERT : ST_RESP;
            ACT_REMOVE_VALUE: state_next = (entry_count != '0) ? ST_SEARCH : ST_RESP;
            ACT_REMOVE_POS:   state_next = pos_ok ? ST_SEARCH : ST_RESP;
            ACT_DUMP:         state_next = (entry_count != '0) ? ST_DUMP : ST_RESP;
            default:          state_next = ST_RESP;
          endcase
        end
      end
      ST_INSERT: state_next = ST_RESP;
      ST_SEARCH: begin
        if (is_match || at_end) state_next = ST_RESP;
      end
      ST_DUMP: begin
        if (out_free && at_end) state_next = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall      = (state != ST_IDLE);
    rd_en         = 1'b0;
    rd_addr       = head;
    value_we      = 1'b0;
    link_we       = 1'b0;
    link_waddr    = tail;
    link_wdata    = alloc_slot;
    out_load      = 1'b0;
    out_load_data = '{ok: resp_ok, out_value: '0,
                      count: COUNT_BITS'(entry_count), last: 1'b1};
    unique case (state)
      ST_IDLE: begin
        rd_en   = in_fire;
        rd_addr = head;
      end
      ST_INSERT: begin
        value_we = 1'b1;
        if (entry_count != '0) begin
          link_we = 1'b1;
          if (req_action == ACT_INSERT_FRONT) begin
            link_waddr = alloc_slot;
            link_wdata = head;
          end else begin
            link_waddr = tail;
            link_wdata = alloc_slot;
          end
        end
      end
      ST_SEARCH: begin
        rd_en   = !is_match && !at_end;
        rd_addr = rd_link;
        // Bypass the removed entry from its predecessor
        if (is_match && walk_idx != '0) begin
          link_we    = 1'b1;
          link_waddr = prev;
          link_wdata = rd_link;
        end
      end
      ST_DUMP: begin
        rd_en         = out_free && !at_end;
        rd_addr       = rd_link;
        out_load      = out_free;
        out_load_data = '{ok: 1'b1, out_value: rd_value,
                          count: COUNT_BITS'(entry_count), last: at_end};
      end
      ST_RESP: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control state and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      free_map    <= '1;
      head        <= '0;
      tail        <= '0;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (state == ST_IDLE && in_fire && act_in == ACT_CLEAR) begin
        free_map    <= '1;
        head        <= '0;
        tail        <= '0;
        entry_count <= '0;
      end

      if (state == ST_INSERT) begin
        free_map[alloc_slot] <= 1'b0;
        entry_count          <= entry_count + CW'(1);
        if (entry_count == '0) begin
          head <= alloc_slot;
          tail <= alloc_slot;
        end else if (req_action == ACT_INSERT_FRONT) begin
          head <= alloc_slot;
        end else begin
          tail <= alloc_slot;
        end
      end

      if (state == ST_SEARCH && is_match) begin
        free_map[cur] <= 1'b1;
        entry_count   <= entry_count - CW'(1);
        if (entry_count == CW'(1)) begin
          head <= '0;
          tail <= '0;
        end else begin
          if (walk_idx == '0) head <= rd_link;
          if (at_end) tail <= prev;
        end
      end
    end
  end

  // Request, walk and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_action <= act_in;
      req_value  <= in_data.item_value;
      target     <= CW'(pos_ext - CMPW'(1));
      cur        <= head;
      prev       <= '0;
      walk_idx   <= '0;
      resp_ok    <= (act_in == ACT_CLEAR);
    end else if (rd_en) begin
      // Advance one link
      prev     <= cur;
      cur      <= rd_link;
      walk_idx <= walk_idx + CW'(1);
    end

    if (state == ST_INSERT || (state == ST_SEARCH && is_match)) begin
      resp_ok <= 1'b1;
    end

    if (out_load) out_data <= out_load_data;
  end

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (value_we) value_mem[alloc_slot] <= req_value;
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
    end
  end

  `ASSERT_ALWAYS(a_count_bound, entry_count <= CW'(CAPACITY), "entry count above capacity")
  `ASSERT_ALWAYS(a_free_balance, ($countones(free_map) + int'(entry_count)) == CAPACITY, "free map and count disagree")
  `ASSERT_IMPLY(a_empty_ptrs, entry_count == '0, head == '0 && tail == '0, "empty list with nonzero pointers")
  `ASSERT_IMPLY(a_insert_room, state == ST_INSERT, free_map != '0, "insert with no free slot")
  `ASSERT_IMPLY(a_partial_dump, out_valid && !out_data.last, state == ST_DUMP, "non-final result outside dump")

endmodule

`default_nettype wire
